### sv/stsp_pkg.sv
// Package for the source token splitter: types, character codes and set lookup.
`timescale 1ns / 1ps
`default_nettype none
package stsp_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [63:0] set_word_t;

  typedef enum logic [1:0] {
    KIND_WORD    = 2'd0,
    KIND_COMMENT = 2'd1,
    KIND_OP      = 2'd2,
    KIND_STOP    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_START   = 2'd0,
    PH_WORD    = 2'd1,
    PH_COMMENT = 2'd2,
    PH_OPTAIL  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    REG_SKIP_LOW  = 2'd0,
    REG_SKIP_HIGH = 2'd1,
    REG_STOP_LOW  = 2'd2,
    REG_STOP_HIGH = 2'd3
  } reg_idx_t;

  localparam byte_t CH_SLASH   = 8'h2F;
  localparam byte_t CH_PLUS    = 8'h2B;
  localparam byte_t CH_EQUAL   = 8'h3D;
  localparam byte_t CH_STAR    = 8'h2A;
  localparam byte_t CH_NEWLINE = 8'h0A;
  localparam byte_t CH_NUL     = 8'h00;

  localparam set_word_t SET_LOW_RST  = 64'h0000_0001_0000_2600;
  localparam set_word_t SET_HIGH_RST = 64'h0;

  // Codes 128 and up are in no set.
  function automatic logic in_set(input set_word_t lo, input set_word_t hi, input byte_t c);
    logic r;
    if (c[7]) begin
      r = 1'b0;
    end else if (c[6]) begin
      r = hi[c[5:0]];
    end else begin
      r = lo[c[5:0]];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/stsp_stream_if.sv
// Valid/ready stream interfaces for source bytes and token bytes.
`timescale 1ns / 1ps
`default_nettype none
interface stsp_in_if;
  logic            valid;
  logic            ready;
  stsp_pkg::byte_t char_byte;
  logic            end_of_text;

  modport source (output valid, output char_byte, output end_of_text, input ready);
  modport sink   (input valid, input char_byte, input end_of_text, output ready);
endinterface

interface stsp_out_if;
  logic            valid;
  logic            ready;
  stsp_pkg::byte_t token_byte;
  logic [1:0]      token_kind;
  logic            token_first;
  logic            token_last;

  modport source (output valid, output token_byte, output token_kind, output token_first,
                  output token_last, input ready);
  modport sink   (input valid, input token_byte, input token_kind, input token_first,
                  input token_last, output ready);
endinterface
`default_nettype wire

### sv/source_token_splitter.sv
// Source token splitter: byte stream in, marked token bytes out.
// Throughput: one source byte per cycle while the result side takes requests.
// Latency: a token byte sits in the result register the cycle after the byte that
//   follows it is accepted (one byte of lookahead held in the state registers).
// End of text or a zero byte flushes the held byte, marked last, into the result register in the same way.
// Reset (synchronous, rst_n low): nothing held, result register empty, sets at defaults.
`timescale 1ns / 1ps
`default_nettype none
module source_token_splitter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  stsp_in_if.sink          in_stream,
  stsp_out_if.source       out_stream,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready
);

  stsp_pkg::set_word_t skip_lo_r, skip_hi_r, stop_lo_r, stop_hi_r;

  stsp_pkg::byte_t  held_byte_r,  held_byte_nxt;
  logic             held_valid_r, held_valid_nxt;
  logic             held_first_r, held_first_nxt;
  stsp_pkg::kind_t  held_kind_r,  held_kind_nxt;
  stsp_pkg::phase_t phase_r,      phase_nxt;

  logic             out_valid_r;
  stsp_pkg::byte_t  out_byte_r,  out_byte_nxt;
  stsp_pkg::kind_t  out_kind_r,  out_kind_nxt;
  logic             out_first_r, out_first_nxt;
  logic             out_last_r,  out_last_nxt;
  logic             emit;

  logic             accept;
  logic             end_in;
  stsp_pkg::byte_t  c;
  stsp_pkg::byte_t  h;
  logic             skip_c, stop_c, stop_h, two_op;
  stsp_pkg::reg_idx_t widx;

  // Configuration port
  assign pready = 1'b1;
  assign widx   = stsp_pkg::reg_idx_t'(paddr[4:3]);

  always_comb begin
    case (widx)
      stsp_pkg::REG_SKIP_LOW:  prdata = skip_lo_r;
      stsp_pkg::REG_SKIP_HIGH: prdata = skip_hi_r;
      stsp_pkg::REG_STOP_LOW:  prdata = stop_lo_r;
      stsp_pkg::REG_STOP_HIGH: prdata = stop_hi_r;
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_lo_r <= stsp_pkg::SET_LOW_RST;
      skip_hi_r <= stsp_pkg::SET_HIGH_RST;
      stop_lo_r <= stsp_pkg::SET_LOW_RST;
      stop_hi_r <= stsp_pkg::SET_HIGH_RST;
    end else if (psel && penable && pwrite) begin
      case (widx)
        stsp_pkg::REG_SKIP_LOW:  skip_lo_r <= pwdata;
        stsp_pkg::REG_SKIP_HIGH: skip_hi_r <= pwdata;
        stsp_pkg::REG_STOP_LOW:  stop_lo_r <= pwdata;
        stsp_pkg::REG_STOP_HIGH: stop_hi_r <= pwdata;
        default: ;
      endcase
    end
  end

  // Handshake: the result register frees up in the same cycle it is taken
  assign in_stream.ready = !out_valid_r || out_stream.ready;
  assign accept          = in_stream.valid && in_stream.ready;

  assign c      = in_stream.char_byte;
  assign h      = held_byte_r;
  assign end_in = in_stream.end_of_text || (c == stsp_pkg::CH_NUL);
  assign skip_c = stsp_pkg::in_set(skip_lo_r, skip_hi_r, c);
  assign stop_c = stsp_pkg::in_set(stop_lo_r, stop_hi_r, c);
  assign stop_h = stsp_pkg::in_set(stop_lo_r, stop_hi_r, h);
  assign two_op = (h == stsp_pkg::CH_PLUS &&
                   (c == stsp_pkg::CH_EQUAL || c == stsp_pkg::CH_PLUS)) ||
                  ((h == stsp_pkg::CH_SLASH || h == stsp_pkg::CH_STAR) &&
                   c == stsp_pkg::CH_EQUAL);

  always_comb begin
    logic fresh;
    fresh          = 1'b0;
    emit           = 1'b0;
    out_byte_nxt   = h;
    out_kind_nxt   = held_kind_r;
    out_first_nxt  = held_first_r;
    out_last_nxt   = 1'b0;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    held_first_nxt = held_first_r;
    held_kind_nxt  = held_kind_r;
    phase_nxt      = phase_r;

    if (end_in) begin
      emit          = held_valid_r;
      out_last_nxt  = 1'b1;
      if (phase_r == stsp_pkg::PH_START) begin
        out_kind_nxt  = stop_h ? stsp_pkg::KIND_STOP : stsp_pkg::KIND_WORD;
        out_first_nxt = 1'b1;
      end
      held_byte_nxt  = '0;
      held_valid_nxt = 1'b0;
      held_first_nxt = 1'b0;
      held_kind_nxt  = stsp_pkg::KIND_WORD;
      phase_nxt      = stsp_pkg::PH_START;
    end else if (!held_valid_r) begin
      fresh = 1'b1;
    end else begin
      emit = 1'b1;
      case (phase_r)
        stsp_pkg::PH_START: begin
          out_first_nxt = 1'b1;
          if (h == stsp_pkg::CH_SLASH && c == stsp_pkg::CH_SLASH) begin
            out_kind_nxt  = stsp_pkg::KIND_COMMENT;
            held_kind_nxt = stsp_pkg::KIND_COMMENT;
            phase_nxt     = stsp_pkg::PH_COMMENT;
          end else if (two_op) begin
            out_kind_nxt  = stsp_pkg::KIND_OP;
            held_kind_nxt = stsp_pkg::KIND_OP;
            phase_nxt     = stsp_pkg::PH_OPTAIL;
          end else if (stop_h) begin
            out_kind_nxt = stsp_pkg::KIND_STOP;
            out_last_nxt = 1'b1;
            fresh        = 1'b1;
          end else if (stop_c) begin
            out_kind_nxt = stsp_pkg::KIND_WORD;
            out_last_nxt = 1'b1;
            fresh        = 1'b1;
          end else begin
            out_kind_nxt  = stsp_pkg::KIND_WORD;
            held_kind_nxt = stsp_pkg::KIND_WORD;
            phase_nxt     = stsp_pkg::PH_WORD;
          end
        end
        stsp_pkg::PH_WORD: begin
          out_kind_nxt = stsp_pkg::KIND_WORD;
          if (stop_c) begin
            out_last_nxt = 1'b1;
            fresh        = 1'b1;
          end
        end
        stsp_pkg::PH_COMMENT: begin
          out_kind_nxt = stsp_pkg::KIND_COMMENT;
          if (c == stsp_pkg::CH_NEWLINE) begin
            out_last_nxt = 1'b1;
            fresh        = 1'b1;
          end
        end
        default: begin
          out_kind_nxt = stsp_pkg::KIND_OP;
          out_last_nxt = 1'b1;
          fresh        = 1'b1;
        end
      endcase
      if (!fresh) begin
        // continue the token with c
        held_byte_nxt  = c;
        held_first_nxt = 1'b0;
      end
    end

    if (fresh) begin
      if (skip_c) begin
        held_valid_nxt = 1'b0;
      end else begin
        held_byte_nxt  = c;
        held_valid_nxt = 1'b1;
        held_first_nxt = 1'b1;
        held_kind_nxt  = stsp_pkg::KIND_WORD;
        phase_nxt      = stsp_pkg::PH_START;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_byte_r  <= '0;
      held_valid_r <= 1'b0;
      held_first_r <= 1'b0;
      held_kind_r  <= stsp_pkg::KIND_WORD;
      phase_r      <= stsp_pkg::PH_START;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        held_byte_r  <= held_byte_nxt;
        held_valid_r <= held_valid_nxt;
        held_first_r <= held_first_nxt;
        held_kind_r  <= held_kind_nxt;
        phase_r      <= phase_nxt;
        out_valid_r  <= emit;
      end else if (out_stream.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_byte_r  <= out_byte_nxt;
      out_kind_r  <= out_kind_nxt;
      out_first_r <= out_first_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_stream.valid       = out_valid_r;
  assign out_stream.token_byte  = out_byte_r;
  assign out_stream.token_kind  = out_kind_r;
  assign out_stream.token_first = out_first_r;
  assign out_stream.token_last  = out_last_r;

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && end_in |=> !held_valid_r)
    else $error("held byte survived end of text");

  a_tail_not_first: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r && phase_r != stsp_pkg::PH_START |-> !held_first_r)
    else $error("continuation byte marked first");

  a_optail_byte: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r && phase_r == stsp_pkg::PH_OPTAIL |->
      held_byte_r == stsp_pkg::CH_EQUAL || held_byte_r == stsp_pkg::CH_PLUS)
    else $error("operator tail holds unexpected byte");

  a_stop_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == stsp_pkg::KIND_STOP |-> out_first_r && out_last_r)
    else $error("stop token longer than one byte");

  a_pair_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_first_r && out_kind_r == stsp_pkg::KIND_OP |-> !out_last_r)
    else $error("operator head marked last");

endmodule
`default_nettype wire
